FILE: rtl/r4rot_pkg.sv
// shared types and constants for the 4d rotor rotation block
package r4rot_pkg;

  localparam int ROT_W      = 16;
  localparam int VEC_W      = 32;
  localparam int MAT_W      = 32;
  localparam int ENT_W      = 36;
  localparam int PROD_W     = 64;
  localparam int SUM_W      = 66;
  localparam int OUT_SHIFT  = 24;
  localparam int ENT_SHIFT  = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int LANES      = 4;

  localparam logic signed [ROT_W-1:0] ROTOR_ONE  = 16'sd16384;
  localparam logic [1:0]              SETTLE_CYC = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALAR = 4'd0,
    REG_B12    = 4'd1,
    REG_B13    = 4'd2,
    REG_B14    = 4'd3,
    REG_B23    = 4'd4,
    REG_B24    = 4'd5,
    REG_B34    = 4'd6,
    REG_PSEUDO = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] s;
    logic signed [ROT_W-1:0] a12;
    logic signed [ROT_W-1:0] a13;
    logic signed [ROT_W-1:0] a14;
    logic signed [ROT_W-1:0] a23;
    logic signed [ROT_W-1:0] a24;
    logic signed [ROT_W-1:0] a34;
    logic signed [ROT_W-1:0] p;
  } rotor_t;

  typedef logic [LANES-1:0][MAT_W-1:0] row_t;
  typedef row_t [LANES-1:0]            mat_t;
  typedef logic [LANES-1:0][VEC_W-1:0] vec4_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

endpackage

FILE: rtl/r4rot_matrix.sv
// expands the rotor into the q.24 rotation matrix over two register stages
module r4rot_matrix import r4rot_pkg::*; (
  input  logic   clk,
  input  rotor_t rotor,
  output mat_t   mat
);

  function automatic logic signed [31:0] mul16(input logic signed [ROT_W-1:0] a,
                                               input logic signed [ROT_W-1:0] b);
    logic signed [31:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic signed [ENT_W-1:0] ext(input logic signed [31:0] v);
    logic signed [ENT_W-1:0] r;
    r = ENT_W'(v);
    return r;
  endfunction

  function automatic logic signed [ENT_W-1:0] dbl(input logic signed [ENT_W-1:0] v);
    logic signed [ENT_W-1:0] r;
    r = {v[ENT_W-2:0], 1'b0};
    return r;
  endfunction

  // round half up from q.28 to q.24
  function automatic logic [MAT_W-1:0] rnd(input logic signed [ENT_W-1:0] v);
    logic signed [ENT_W-1:0] t;
    t = v + ENT_W'(1 << (ENT_SHIFT - 1));
    return t[ENT_W-1:ENT_SHIFT];
  endfunction

  // squares
  logic signed [31:0] q_s_r, q_12_r, q_13_r, q_14_r, q_23_r, q_24_r, q_34_r, q_p_r;
  // cross products
  logic signed [31:0] x_s12_r, x_s13_r, x_s14_r, x_s23_r, x_s24_r, x_s34_r;
  logic signed [31:0] x_13_23_r, x_14_24_r, x_34_p_r, x_12_23_r, x_14_34_r, x_24_p_r;
  logic signed [31:0] x_12_24_r, x_13_34_r, x_23_p_r, x_12_13_r, x_24_34_r, x_14_p_r;
  logic signed [31:0] x_12_14_r, x_23_34_r, x_13_p_r, x_13_14_r, x_23_24_r, x_12_p_r;

  mat_t mat_r;
  mat_t mat_nxt;

  always_ff @(posedge clk) begin
    q_s_r     <= mul16(rotor.s,   rotor.s);
    q_12_r    <= mul16(rotor.a12, rotor.a12);
    q_13_r    <= mul16(rotor.a13, rotor.a13);
    q_14_r    <= mul16(rotor.a14, rotor.a14);
    q_23_r    <= mul16(rotor.a23, rotor.a23);
    q_24_r    <= mul16(rotor.a24, rotor.a24);
    q_34_r    <= mul16(rotor.a34, rotor.a34);
    q_p_r     <= mul16(rotor.p,   rotor.p);
    x_s12_r   <= mul16(rotor.s,   rotor.a12);
    x_s13_r   <= mul16(rotor.s,   rotor.a13);
    x_s14_r   <= mul16(rotor.s,   rotor.a14);
    x_s23_r   <= mul16(rotor.s,   rotor.a23);
    x_s24_r   <= mul16(rotor.s,   rotor.a24);
    x_s34_r   <= mul16(rotor.s,   rotor.a34);
    x_13_23_r <= mul16(rotor.a13, rotor.a23);
    x_14_24_r <= mul16(rotor.a14, rotor.a24);
    x_34_p_r  <= mul16(rotor.a34, rotor.p);
    x_12_23_r <= mul16(rotor.a12, rotor.a23);
    x_14_34_r <= mul16(rotor.a14, rotor.a34);
    x_24_p_r  <= mul16(rotor.a24, rotor.p);
    x_12_24_r <= mul16(rotor.a12, rotor.a24);
    x_13_34_r <= mul16(rotor.a13, rotor.a34);
    x_23_p_r  <= mul16(rotor.a23, rotor.p);
    x_12_13_r <= mul16(rotor.a12, rotor.a13);
    x_24_34_r <= mul16(rotor.a24, rotor.a34);
    x_14_p_r  <= mul16(rotor.a14, rotor.p);
    x_12_14_r <= mul16(rotor.a12, rotor.a14);
    x_23_34_r <= mul16(rotor.a23, rotor.a34);
    x_13_p_r  <= mul16(rotor.a13, rotor.p);
    x_13_14_r <= mul16(rotor.a13, rotor.a14);
    x_23_24_r <= mul16(rotor.a23, rotor.a24);
    x_12_p_r  <= mul16(rotor.a12, rotor.p);
  end

  always_comb begin
    mat_nxt[0][0] = rnd(ext(q_s_r) - ext(q_12_r) - ext(q_13_r) - ext(q_14_r)
                      + ext(q_23_r) + ext(q_24_r) + ext(q_34_r) - ext(q_p_r));
    mat_nxt[0][1] = rnd(dbl(ext(x_s12_r) + ext(x_13_23_r) + ext(x_14_24_r) + ext(x_34_p_r)));
    mat_nxt[0][2] = rnd(dbl(ext(x_s13_r) - ext(x_12_23_r) + ext(x_14_34_r) - ext(x_24_p_r)));
    mat_nxt[0][3] = rnd(dbl(ext(x_s14_r) - ext(x_12_24_r) - ext(x_13_34_r) + ext(x_23_p_r)));

    mat_nxt[1][0] = rnd(dbl(-ext(x_s12_r) + ext(x_13_23_r) + ext(x_14_24_r) - ext(x_34_p_r)));
    mat_nxt[1][1] = rnd(ext(q_s_r) - ext(q_12_r) - ext(q_23_r) - ext(q_24_r)
                      + ext(q_13_r) + ext(q_14_r) + ext(q_34_r) - ext(q_p_r));
    mat_nxt[1][2] = rnd(dbl(ext(x_s23_r) + ext(x_12_13_r) + ext(x_24_34_r) + ext(x_14_p_r)));
    mat_nxt[1][3] = rnd(dbl(ext(x_s24_r) + ext(x_12_14_r) - ext(x_23_34_r) - ext(x_13_p_r)));

    mat_nxt[2][0] = rnd(dbl(-ext(x_s13_r) - ext(x_12_23_r) + ext(x_14_34_r) + ext(x_24_p_r)));
    mat_nxt[2][1] = rnd(dbl(-ext(x_s23_r) + ext(x_12_13_r) + ext(x_24_34_r) - ext(x_14_p_r)));
    mat_nxt[2][2] = rnd(ext(q_s_r) - ext(q_13_r) - ext(q_23_r) - ext(q_34_r)
                      + ext(q_12_r) + ext(q_14_r) + ext(q_24_r) - ext(q_p_r));
    mat_nxt[2][3] = rnd(dbl(ext(x_s34_r) + ext(x_13_14_r) + ext(x_23_24_r) + ext(x_12_p_r)));

    mat_nxt[3][0] = rnd(dbl(-ext(x_s14_r) - ext(x_12_24_r) - ext(x_13_34_r) - ext(x_23_p_r)));
    mat_nxt[3][1] = rnd(dbl(-ext(x_s24_r) + ext(x_12_14_r) - ext(x_23_34_r) + ext(x_13_p_r)));
    mat_nxt[3][2] = rnd(dbl(-ext(x_s34_r) + ext(x_13_14_r) + ext(x_23_24_r) - ext(x_12_p_r)));
    mat_nxt[3][3] = rnd(ext(q_s_r) - ext(q_14_r) - ext(q_24_r) - ext(q_34_r)
                      + ext(q_12_r) + ext(q_13_r) + ext(q_23_r) - ext(q_p_r));
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign mat = mat_r;

endmodule

FILE: rtl/r4rot_lane.sv
// one output row: four products, then their exact sum
module r4rot_lane import r4rot_pkg::*; (
  input  logic                    clk,
  input  lane_ctl_t               ctl,
  input  row_t                    row,
  input  vec4_t                   vec,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [PROD_W-1:0] prod_r [LANES];
  logic signed [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int j = 0; j < LANES; j++) begin
        prod_r[j] <= $signed(row[j]) * $signed(vec[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      sum_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
             + SUM_W'(prod_r[3]);
    end
  end

  assign sum = sum_r;

endmodule

FILE: rtl/r4rot_merge.sv
// collects the lane sums, rounds to q16.16 with saturation, holds the result item
module r4rot_merge import r4rot_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic [LANES-1:0][SUM_W-1:0] sums,
  output vec4_t                   res
);

  vec4_t res_r;
  vec4_t res_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [SUM_W-1:0]           t;
      logic [SUM_W-OUT_SHIFT-VEC_W:0] hi;
      t  = sums[i] + (SUM_W'(1) << (OUT_SHIFT - 1));
      hi = t[SUM_W-1:OUT_SHIFT+VEC_W-1];
      // upper bits all equal means the rounded value fits in 32 bits
      if ((&hi) || !(|hi)) begin
        res_nxt[i] = t[OUT_SHIFT+VEC_W-1:OUT_SHIFT];
      end else if (t[SUM_W-1]) begin
        res_nxt[i] = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
        res_nxt[i] = {1'b0, {(VEC_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/rotor4d_rotate_vector.sv
// top level: rotor registers, matrix build, four row lanes and the result stage
//
// Rotates 4d q16.16 vectors by a rotor held in eight q2.14 registers.
// Configuration: write cfg_data to register cfg_index when cfg_valid and
// cfg_ready are both high; cfg_ready is always high and indexes above seven
// are ignored. After a write the rotor matrix is rebuilt through the product
// and matrix registers, during which in_stall is held high.
// Input channel: in_x..in_w are taken at an edge where in_valid is high and
// in_stall is low. Result channel: out_x..out_w leave at an edge where
// out_valid is high and out_stall is low.
// Each item passes the product registers, the lane sums and the result
// register in that order. Throughput: one item per cycle while in_stall
// and out_stall are low; the four lanes each multiply one matrix row by
// the vector, so in each such cycle a full vector goes through.
// When the receiver stalls, the result holds and the stages behind it keep
// filling until each holds an item; only then is in_stall raised.
// Reset: the rotor returns to identity, the pipeline empties and the
// matrix is rebuilt, with in_stall held high until the rebuild is done.
module rotor4d_rotate_vector import r4rot_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [ROT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic signed [VEC_W-1:0] in_z,
  input  logic signed [VEC_W-1:0] in_w,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEC_W-1:0] out_x,
  output logic signed [VEC_W-1:0] out_y,
  output logic signed [VEC_W-1:0] out_z,
  output logic signed [VEC_W-1:0] out_w
);

  rotor_t     rot_r;
  rotor_t     rot_nxt;
  logic [1:0] settle_r;
  logic [1:0] settle_nxt;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       s2_valid_r;
  logic       s2_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  logic       cfg_wr;
  logic       in_acc;
  logic       out_free;
  logic       s2_move;
  logic       s2_free;
  logic       s1_move;
  logic       s1_free;
  lane_ctl_t  ctl;
  mat_t       mat;
  vec4_t      vec;
  vec4_t      res;
  logic [LANES-1:0][SUM_W-1:0] sums;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    rot_nxt = rot_r;
    if (cfg_wr) begin
      case (cfg_index)
        REG_SCALAR: rot_nxt.s   = cfg_data;
        REG_B12:    rot_nxt.a12 = cfg_data;
        REG_B13:    rot_nxt.a13 = cfg_data;
        REG_B14:    rot_nxt.a14 = cfg_data;
        REG_B23:    rot_nxt.a23 = cfg_data;
        REG_B24:    rot_nxt.a24 = cfg_data;
        REG_B34:    rot_nxt.a34 = cfg_data;
        REG_PSEUDO: rot_nxt.p   = cfg_data;
        default:    rot_nxt     = rot_r;
      endcase
    end
  end

  // matrix rebuild runs behind the rotor registers, through the product and matrix registers
  always_comb begin
    if (cfg_wr) begin
      settle_nxt = SETTLE_CYC;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s2_move  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_move  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = (settle_r != 2'd0) || !s1_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_move);
    s2_valid_nxt  = s1_move || (s2_valid_r && !s2_move);
    out_valid_nxt = s2_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r       <= '{s: ROTOR_ONE, default: '0};
      settle_r    <= SETTLE_CYC;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rot_r       <= rot_nxt;
      settle_r    <= settle_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ctl.s1_en = in_acc;
  assign ctl.s2_en = s1_move;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  r4rot_matrix u_matrix (
    .clk   (clk),
    .rotor (rot_r),
    .mat   (mat)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    r4rot_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .row (mat[i]),
      .vec (vec),
      .sum (sums[i])
    );
  end

  r4rot_merge u_merge (
    .clk  (clk),
    .load (s2_move),
    .sums (sums),
    .res  (res)
  );

  assign out_valid = out_valid_r;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];

  logic [2:0] occ;
  assign occ = {s1_valid_r, s2_valid_r, out_valid_r};

  // a configuration write must block items while the matrix is rebuilt
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_stall)
    else $error("item could be taken right after a rotor write");

  a_settle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> settle_r == 2'd0)
    else $error("item taken while the matrix was stale");

  // items in flight go up by one when one enters and none leaves
  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !(out_valid && !out_stall)) |=>
      $countones(occ) == $past($countones(occ)) + 1)
    else $error("item lost or duplicated in the pipeline");

  a_occ_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && out_valid && !out_stall) |=>
      $countones(occ) + 1 == $past($countones(occ)))
    else $error("item count wrong after a result left");

endmodule
